// ===== rtl/core/sipd_pkg.sv =====
// Shared types and constants for the shift-coefficient IIR low-pass with peak detect.
// Used by every module under rtl/core; no dependencies.
`default_nettype none

package sipd_pkg;

   localparam int PREC_W      = 32;   // precise (widened) value width
   localparam int SAMPLE_W    = 16;   // regular-precision width
   localparam int SHIFT_W     = 4;    // width of the shift registers
   localparam int EFB_DEFAULT = 16;   // extra fraction bits, default

   localparam int REQ_DATA_W  = 16;   // sample
   localparam int RSP_DATA_W  = 40;   // filtered, pos, neg, peak_value, pad
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_SHIFT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_SHIFT = 1'b1;

   localparam logic [SHIFT_W-1:0] INPUT_SHIFT_RST   = 4'd4;
   localparam logic [SHIFT_W-1:0] DAMPING_SHIFT_RST = 4'd2;

   localparam logic MODE_INIT = 1'b0;
   localparam logic MODE_ADD  = 1'b1;

   // Output history after the update of the current item
   typedef struct packed {
      logic signed [PREC_W-1:0] y0;
      logic signed [PREC_W-1:0] y1;
      logic signed [PREC_W-1:0] y2;
   } taps_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] peak_value;
      logic                       neg_peak;
      logic                       pos_peak;
      logic signed [SAMPLE_W-1:0] filtered;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/shift_iir_lowpass_peak_detect_core.sv =====
// Top level: stream handshake, input and result registers, config registers.
// Depends on sipd_pkg, sipd_filter, sipd_peak.
//
//  channel   ports                         payload
//  req       req_tvalid/tready/tdata/tuser tdata: sample[15:0]; tuser: mode
//  rsp       rsp_tvalid/tready/tdata       filtered, pos_peak, neg_peak, peak_value
//  csr       csr_we/index/wdata            0: input_shift, 1: damping_shift
//
// One transaction per clock sustained while rsp_tready is high; rsp_tvalid rises
// after the req accept has passed the input register, then the result register.
// The filter recursion is combinational between the two registers.
// Reset is synchronous: histories clear to zero, shifts go to 4 and 2.
// A stalled rsp side holds the result register; req_tready drops only when
// both the input register and the result register are full.
`default_nettype none

module shift_iir_lowpass_peak_detect_core
   import sipd_pkg::*;
#(
   parameter int EXTRA_FRACTION_BITS = EFB_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   input  wire logic                  req_tuser,   // [0] mode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] filtered, [16] pos_peak, [17] neg_peak, [33:18] peak_value, rest zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SHIFT_W-1:0]    csr_wdata
);

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_mode_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_data_ff;
   logic [SHIFT_W-1:0]         input_shift_ff, damping_shift_ff;

   logic       req_fire;
   logic       out_ready;
   logic       step;
   taps_type   taps;
   result_type res;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff   <= req_tuser;
         s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (step) begin
         rsp_data_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_shift_ff   <= INPUT_SHIFT_RST;
         damping_shift_ff <= DAMPING_SHIFT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INPUT_SHIFT:   input_shift_ff   <= csr_wdata;
            CSR_DAMPING_SHIFT: damping_shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sipd_filter #(
      .EXTRA_FRACTION_BITS(EXTRA_FRACTION_BITS)
   ) u_filter (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .mode          (s1_mode_ff),
      .sample        (s1_sample_ff),
      .input_shift   (input_shift_ff),
      .damping_shift (damping_shift_ff),
      .taps          (taps)
   );

   sipd_peak #(
      .EXTRA_FRACTION_BITS(EXTRA_FRACTION_BITS)
   ) u_peak (
      .taps (taps),
      .res  (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // A peak cannot be both a maximum and a minimum
   a_peak_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pos_peak && rsp_data_ff.neg_peak))
      else $error("both peak flags set");

   // peak_value is zero unless a flag is set
   a_peak_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.pos_peak && !rsp_data_ff.neg_peak)
         |-> (rsp_data_ff.peak_value == '0))
      else $error("peak_value without peak flag");

   // Init item always gives no peak
   a_init_no_peak: assert property (@(posedge clock) disable iff (reset)
      (step && s1_mode_ff == MODE_INIT) |=> !rsp_data_ff.pos_peak && !rsp_data_ff.neg_peak)
      else $error("peak flagged on init item");

   // Input back-pressure only while the whole pipe is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("req_tready low without a full stalled pipe");

endmodule

`default_nettype wire

// ===== rtl/core/sipd_filter.sv =====
// History registers and the shift-and-add recursion of the second-order filter.
// Depends on sipd_pkg.
`default_nettype none

module sipd_filter
   import sipd_pkg::*;
#(
   parameter int EXTRA_FRACTION_BITS = EFB_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       mode,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic [SHIFT_W-1:0]         input_shift,
   input  wire logic [SHIFT_W-1:0]         damping_shift,
   output taps_type                        taps
);

   // Only the two newest entries of each history are needed: the oldest
   // one is always overwritten before it is read.
   logic signed [PREC_W-1:0] x_ff [2];
   logic signed [PREC_W-1:0] y_ff [2];
   logic signed [PREC_W-1:0] x_in [2];
   logic signed [PREC_W-1:0] y_in [2];

   logic signed [PREC_W-1:0] wide;
   logic signed [PREC_W-1:0] sum;
   logic [SHIFT_W-1:0]       a1;
   logic [SHIFT_W-1:0]       a2;

   assign wide = PREC_W'(sample) <<< EXTRA_FRACTION_BITS;
   assign a1   = (input_shift >= SHIFT_W'(1)) ? input_shift - SHIFT_W'(1) : '0;
   assign a2   = (input_shift >= SHIFT_W'(2)) ? input_shift - SHIFT_W'(2) : '0;

   // new y2 = y_ff[1], new y1 = y_ff[0], new x2 = x_ff[1], new x1 = x_ff[0]
   always_comb begin
      sum = (y_ff[0] - y_ff[1]) + y_ff[0];
      sum = sum - (y_ff[0] >>> damping_shift) + (y_ff[1] >>> damping_shift);
      sum = sum + (wide >>> input_shift) + (x_ff[0] >>> a1) + (x_ff[1] >>> input_shift);
      sum = sum - (y_ff[1] >>> a2);
   end

   always_comb begin
      if (mode == MODE_INIT) begin
         x_in[0] = wide;
         x_in[1] = wide;
         y_in[0] = wide;
         y_in[1] = wide;
         taps.y0 = wide;
         taps.y1 = wide;
         taps.y2 = wide;
      end else begin
         x_in[0] = wide;
         x_in[1] = x_ff[0];
         y_in[0] = sum;
         y_in[1] = y_ff[0];
         taps.y0 = sum;
         taps.y1 = y_ff[0];
         taps.y2 = y_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff[0] <= '0;
         x_ff[1] <= '0;
         y_ff[0] <= '0;
         y_ff[1] <= '0;
      end else if (step) begin
         x_ff[0] <= x_in[0];
         x_ff[1] <= x_in[1];
         y_ff[0] <= y_in[0];
         y_ff[1] <= y_in[1];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sipd_peak.sv =====
// Local peak test on the updated output history and narrowing to regular precision.
// Depends on sipd_pkg.
`default_nettype none

module sipd_peak
   import sipd_pkg::*;
#(
   parameter int EXTRA_FRACTION_BITS = EFB_DEFAULT
) (
   input  wire taps_type taps,
   output result_type    res
);

   logic pos;
   logic neg;

   assign pos = (taps.y0 < taps.y1) && (taps.y1 >= taps.y2);
   assign neg = (taps.y0 > taps.y1) && (taps.y1 <= taps.y2);

   always_comb begin
      res.filtered   = taps.y0[EXTRA_FRACTION_BITS +: SAMPLE_W];
      res.pos_peak   = pos;
      res.neg_peak   = neg;
      res.peak_value = (pos || neg) ? taps.y1[EXTRA_FRACTION_BITS +: SAMPLE_W] : '0;
   end

endmodule

`default_nettype wire
